// ===== src/kbt_pkg.sv =====
// shared constants, types and state codes of the k-bucket routing table
package kbt_pkg;

  // table geometry
  localparam int ID_BITS        = 64;
  localparam int BUCKET_ENTRIES = 8;

  // fixed port widths
  localparam int PORT_ID_W  = 64;
  localparam int BUCKET_W   = 6;
  localparam int KIND_W     = 2;

  // derived widths
  localparam int BKT_W   = $clog2(ID_BITS);
  localparam int SLOT_W  = (BUCKET_ENTRIES > 1) ? $clog2(BUCKET_ENTRIES) : 1;
  localparam int FILL_W  = $clog2(BUCKET_ENTRIES + 1);
  localparam int ADDR_W  = BKT_W + SLOT_W;
  localparam int ENT_W   = ID_BITS + 1;

  // leading-one search, one chunk per cycle
  localparam int CHUNK   = 8;
  localparam int CHUNK_W = $clog2(CHUNK);
  localparam int NCHUNK  = (ID_BITS + CHUNK - 1) / CHUNK;
  localparam int PAD_W   = NCHUNK * CHUNK;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_SET    = 2'd3
  } kbt_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_FILL,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_COMMIT,
    ST_RESULT
  } kbt_state_e;

  typedef struct packed {
    logic               start;
    logic [ID_BITS-1:0] xdist;
  } kbt_lzc_req_t;

  typedef struct packed {
    logic             done;
    logic [BKT_W-1:0] bucket;
  } kbt_lzc_rsp_t;

  typedef struct packed {
    logic             ok;
    logic [BKT_W-1:0] bucket;
    logic             present;
    logic             palive;
  } kbt_res_t;

endpackage

// ===== src/kbt_if.sv =====
// handshake channels of the k-bucket routing table: request, result and config words
interface kbt_in_if import kbt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [PORT_ID_W-1:0] node_id;
  logic                 alive;

  modport source (output valid, kind, node_id, alive, input ready);
  modport sink (input valid, kind, node_id, alive, output ready);
endinterface

interface kbt_out_if import kbt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                ok;
  logic [BUCKET_W-1:0] bucket;
  logic                present;
  logic                present_alive;

  modport source (output valid, ok, bucket, present, present_alive, input ready);
  modport sink (input valid, ok, bucket, present, present_alive, output ready);
endinterface

interface kbt_cfg_if import kbt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [PORT_ID_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== src/kbt_lzc.sv =====
// iterative leading-one search on the xor distance, one chunk per cycle
module kbt_lzc import kbt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  kbt_lzc_req_t req_i,
  output kbt_lzc_rsp_t rsp_o
);

  logic [PAD_W-1:0]   sh_q, sh_d;
  logic [BKT_W-1:0]   pos_q, pos_d;
  logic [BKT_W-1:0]   bkt_q, bkt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CHUNK-1:0]   top;
  logic [CHUNK_W-1:0] lead;

  // offset of the first set bit in the top chunk
  always_comb begin
    top  = sh_q[PAD_W-1 -: CHUNK];
    lead = '0;
    for (int i = 0; i < CHUNK; i++) begin
      if (top[i]) begin
        lead = CHUNK_W'(CHUNK - 1 - i);
      end
    end
  end

  always_comb begin
    sh_d   = sh_q;
    pos_d  = pos_q;
    bkt_d  = bkt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      sh_d   = PAD_W'(req_i.xdist) << (PAD_W - ID_BITS);
      pos_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (top != '0) begin
        bkt_d  = pos_q + BKT_W'(lead);
        busy_d = 1'b0;
        done_d = 1'b1;
      end else if (pos_q == BKT_W'((NCHUNK - 1) * CHUNK)) begin
        // equal ids fall into the last bucket
        bkt_d  = BKT_W'(ID_BITS - 1);
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        sh_d  = sh_q << CHUNK;
        pos_d = pos_q + BKT_W'(CHUNK);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    pos_q <= pos_d;
    bkt_q <= bkt_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.bucket = bkt_q;

endmodule

// ===== src/kbt_engine.sv =====
// bucket sequencer: scans, shifts and rewrites one bucket through the entry memory
module kbt_engine import kbt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  kbt_kind_e          kind_i,
  input  logic [ID_BITS-1:0] id_i,
  input  logic               alive_i,
  input  logic [ID_BITS-1:0] local_id_i,
  output logic               idle_o,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output kbt_res_t           res_o
);

  kbt_state_e state_q, state_d;
  kbt_lzc_req_t lzc_req;
  kbt_lzc_rsp_t lzc_rsp;

  // item registers
  kbt_kind_e          kind_q;
  logic [ID_BITS-1:0] id_q;
  logic               alive_q;
  logic               is_local_q;

  // scan and shift bookkeeping
  logic [FILL_W-1:0] fill_q;
  logic [FILL_W-1:0] cnt_q;
  logic              pend_q;
  logic [SLOT_W-1:0] pidx_q;
  logic              hit_q;
  logic [SLOT_W-1:0] slot_q;
  logic              hit_alive_q;
  logic              old_alive_q;

  // decided action
  logic              wr_q;
  logic [SLOT_W-1:0] wslot_q;
  logic [FILL_W-1:0] nfill_q;
  logic              ok_q, present_q, palive_q;

  logic              d_ok, d_present, d_palive, d_shift, d_wr;
  logic [FILL_W-1:0] d_sstart, d_nfill;
  logic [SLOT_W-1:0] d_wslot;

  // memories
  logic [ENT_W-1:0]  ent_mem [2**ADDR_W];
  logic [ENT_W-1:0]  rd_q;
  logic [FILL_W-1:0] fill_mem [2**BKT_W];
  logic [FILL_W-1:0] fill_rd_q;
  logic              fill_rv_q;
  logic [2**BKT_W-1:0] fill_vld_q;

  logic [BKT_W-1:0]  bkt;
  logic              re, we, fill_we, match;
  logic [ADDR_W-1:0] raddr, waddr;
  logic [ENT_W-1:0]  wdata;

  kbt_lzc u_lzc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (lzc_req),
    .rsp_o  (lzc_rsp)
  );

  assign bkt           = lzc_rsp.bucket;
  assign lzc_req.start = (state_q == ST_IDLE) && start_i;
  assign lzc_req.xdist = id_i ^ local_id_i;

  assign re    = ((state_q == ST_SCAN) || (state_q == ST_SHIFT)) && (cnt_q < fill_q);
  assign raddr = {bkt, cnt_q[SLOT_W-1:0]};
  assign match = (rd_q[ID_BITS-1:0] == id_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (start_i) state_d = ST_FIND;
      ST_FIND:   if (lzc_rsp.done) state_d = ST_FILL;
      ST_FILL:   state_d = ST_SCAN;
      ST_SCAN:   if (!re && !pend_q) state_d = ST_DECIDE;
      ST_DECIDE: state_d = d_shift ? ST_SHIFT : ST_COMMIT;
      ST_SHIFT:  if (!re && !pend_q) state_d = ST_COMMIT;
      ST_COMMIT: state_d = ST_RESULT;
      ST_RESULT: if (res_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    idle_o      = (state_q == ST_IDLE);
    res_valid_o = (state_q == ST_RESULT);
    we          = 1'b0;
    waddr       = {bkt, wslot_q};
    wdata       = {alive_q, id_q};
    fill_we     = 1'b0;
    case (state_q)
      ST_SHIFT: begin
        // move the entry just read one place older
        we    = pend_q;
        waddr = {bkt, pidx_q - SLOT_W'(1)};
        wdata = rd_q;
      end
      ST_COMMIT: begin
        we      = wr_q;
        fill_we = 1'b1;
      end
      default: ;
    endcase
  end

  // action once the bucket has been scanned
  always_comb begin
    d_ok      = 1'b0;
    d_present = 1'b0;
    d_palive  = 1'b0;
    d_shift   = 1'b0;
    d_sstart  = fill_q;
    d_wr      = 1'b0;
    d_wslot   = slot_q;
    d_nfill   = fill_q;
    case (kind_q)
      KIND_ADD: begin
        if (!is_local_q) begin
          if (hit_q) begin
            d_ok     = 1'b1;
            d_shift  = 1'b1;
            d_sstart = FILL_W'(slot_q) + FILL_W'(1);
            d_wr     = 1'b1;
            d_wslot  = SLOT_W'(fill_q - FILL_W'(1));
          end else if (fill_q < FILL_W'(BUCKET_ENTRIES)) begin
            d_ok    = 1'b1;
            d_wr    = 1'b1;
            d_wslot = fill_q[SLOT_W-1:0];
            d_nfill = fill_q + FILL_W'(1);
          end else if (!old_alive_q) begin
            // evict the stale oldest entry
            d_ok     = 1'b1;
            d_shift  = 1'b1;
            d_sstart = FILL_W'(1);
            d_wr     = 1'b1;
            d_wslot  = SLOT_W'(fill_q - FILL_W'(1));
          end
        end
      end
      KIND_REMOVE: begin
        if (hit_q) begin
          d_ok     = 1'b1;
          d_shift  = 1'b1;
          d_sstart = FILL_W'(slot_q) + FILL_W'(1);
          d_nfill  = fill_q - FILL_W'(1);
        end
      end
      KIND_LOOKUP: begin
        d_present = hit_q;
        d_palive  = hit_q && hit_alive_q;
      end
      KIND_SET: begin
        if (hit_q) begin
          d_ok = 1'b1;
          d_wr = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE) begin
        pend_q <= 1'b0;
      end else if ((state_q == ST_SCAN) || (state_q == ST_SHIFT)) begin
        pend_q <= re;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          kind_q      <= kind_i;
          id_q        <= id_i;
          alive_q     <= alive_i;
          is_local_q  <= (id_i == local_id_i);
          hit_q       <= 1'b0;
          old_alive_q <= 1'b0;
        end
      end
      ST_FILL: begin
        fill_q <= fill_rv_q ? fill_rd_q : '0;
        cnt_q  <= '0;
      end
      ST_SCAN: begin
        if (re) begin
          cnt_q  <= cnt_q + FILL_W'(1);
          pidx_q <= cnt_q[SLOT_W-1:0];
        end
        if (pend_q) begin
          if (match && !hit_q) begin
            hit_q       <= 1'b1;
            slot_q      <= pidx_q;
            hit_alive_q <= rd_q[ID_BITS];
          end
          if (pidx_q == '0) begin
            old_alive_q <= rd_q[ID_BITS];
          end
        end
      end
      ST_DECIDE: begin
        cnt_q     <= d_sstart;
        wr_q      <= d_wr;
        wslot_q   <= d_wslot;
        nfill_q   <= d_nfill;
        ok_q      <= d_ok;
        present_q <= d_present;
        palive_q  <= d_palive;
      end
      ST_SHIFT: begin
        if (re) begin
          cnt_q  <= cnt_q + FILL_W'(1);
          pidx_q <= cnt_q[SLOT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      ent_mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= ent_mem[raddr];
    end
  end

  // fill counts, valid bit per bucket stands in for the zero reset
  always_ff @(posedge clk_i) begin
    if (fill_we) begin
      fill_mem[bkt] <= nfill_q;
    end
    fill_rd_q <= fill_mem[bkt];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_vld_q <= '0;
      fill_rv_q  <= 1'b0;
    end else begin
      if (fill_we) begin
        fill_vld_q[bkt] <= 1'b1;
      end
      fill_rv_q <= fill_vld_q[bkt];
    end
  end

  assign res_o.ok      = ok_q;
  assign res_o.bucket  = bkt;
  assign res_o.present = present_q;
  assign res_o.palive  = palive_q;

endmodule

// ===== src/xor_distance_kbucket_table.sv =====
// top level of the xor distance k-bucket routing table
// flow: leading-one search over 1..8 chunks of 8 bits, fill count read, bucket scan, decide,
//   an optional shift pass that moves entries one place, commit, then the result word
// a new word is taken only after the previous result word has moved to the output register;
// scan and shift passes read one entry per memory cycle
// reset: local id clears to zero, every bucket reads as empty at once, input ready at once
module xor_distance_kbucket_table import kbt_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  kbt_in_if.sink    in_i,
  kbt_out_if.source out_o,
  kbt_cfg_if.sink   cfg_i
);

  logic [ID_BITS-1:0] local_id_q;

  logic     eng_idle;
  logic     res_valid;
  logic     res_ready;
  kbt_res_t res;
  logic     start;

  // output register
  logic                ov_q, ov_d;
  logic                ok_q;
  logic [BUCKET_W-1:0] bucket_q;
  logic                present_q;
  logic                palive_q;
  logic                load;

  // config word is always taken, the sequencer samples local id only when a word starts
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_id_q <= '0;
    end else if (cfg_i.valid) begin
      local_id_q <= cfg_i.data[ID_BITS-1:0];
    end
  end

  // a new request word enters once the sequencer is back in idle,
  // even while the previous result word still waits downstream
  assign in_i.ready = eng_idle;
  assign start      = in_i.valid && eng_idle;

  kbt_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .kind_i      (kbt_kind_e'(in_i.kind)),
    .id_i        (in_i.node_id[ID_BITS-1:0]),
    .alive_i     (in_i.alive),
    .local_id_i  (local_id_q),
    .idle_o      (eng_idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // result word moves into the output register when it is free or draining
  assign res_ready = !ov_q || out_o.ready;
  assign load      = res_valid && res_ready;

  always_comb begin
    ov_d = ov_q;
    if (load) begin
      ov_d = 1'b1;
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ok_q      <= res.ok;
      bucket_q  <= BUCKET_W'(res.bucket);
      present_q <= res.present;
      palive_q  <= res.palive;
    end
  end

  assign out_o.valid         = ov_q;
  assign out_o.ok            = ok_q;
  assign out_o.bucket        = bucket_q;
  assign out_o.present       = present_q;
  assign out_o.present_alive = palive_q;

endmodule
